>>> rtl/nrfe_pkg.sv
package nrfe_pkg;

   // sentence limits
   localparam int LINE_LIMIT  = 75;
   localparam int TIME_CHARS  = 10;
   localparam int LAT_CHARS   = 10;
   localparam int LON_CHARS   = 11;
   localparam int HEADER_LAST = 5;

   // widest field the result word can carry
   localparam int MAX_CHARS   = 11;
   localparam int CHARS_W     = MAX_CHARS * 8;
   localparam int LOW_W       = 64;
   localparam int HIGH_W      = CHARS_W - LOW_W;
   localparam int SLOTS       = 5;

   localparam int POS_W       = $clog2(LINE_LIMIT + 1);
   localparam int FCC_W       = $clog2(MAX_CHARS + 1);
   localparam int LEN_W       = 4;
   localparam int COMMA_W     = 3;
   localparam logic [COMMA_W-1:0] COMMA_MAX = 3'd7;

   localparam int QUEUE_DEPTH = 2;

   // characters
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_COMMA   = 8'h2c;
   localparam logic [7:0] CH_M       = 8'h4d;
   localparam logic [7:0] CH_C       = 8'h43;
   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;

   typedef enum logic [2:0] {
      CODE_TIME  = 3'd0,
      CODE_LAT   = 3'd1,
      CODE_NS    = 3'd2,
      CODE_LON   = 3'd3,
      CODE_EW    = 3'd4,
      CODE_ERROR = 3'd5
   } field_code_type;

   // one finished sentence, handed from the parser to the record stage
   typedef struct packed {
      logic                            complete;
      logic                            fix;
      logic [SLOTS-1:0][LEN_W-1:0]     lens;
      logic [SLOTS-1:0][CHARS_W-1:0]   chars;
   } sentence_type;

   function automatic logic [FCC_W-1:0] slot_cap(input logic [2:0] slot);
      logic [FCC_W-1:0] cap;
      unique case (slot)
         CODE_TIME: cap = FCC_W'(TIME_CHARS);
         CODE_LAT:  cap = FCC_W'(LAT_CHARS);
         CODE_LON:  cap = FCC_W'(LON_CHARS);
         default:   cap = FCC_W'(1);
      endcase
      return cap;
   endfunction

endpackage

>>> rtl/nrfe_front.sv
module nrfe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [7:0]            byte_data,
   input  logic                  queue_full,
   output logic                  byte_ready,
   output logic                  push,
   output nrfe_pkg::sentence_type push_data
);
   import nrfe_pkg::*;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [7:0]         hdr_ff [0:2];
   logic [7:0]         hdr_in [0:2];
   logic [COMMA_W-1:0] comma_ff, comma_in;
   logic [FCC_W-1:0]   fcc_ff, fcc_in;
   logic [7:0]         status_ff, status_in;
   logic [LEN_W-1:0]   lens_ff [0:SLOTS-1];
   logic [LEN_W-1:0]   lens_in [0:SLOTS-1];
   logic [CHARS_W-1:0] chars_ff [0:SLOTS-1];

   logic               accept;
   logic [POS_W-1:0]   pos_base;
   logic               start;
   logic               in_header;
   logic               hdr_ok;
   logic               nl_emit;
   logic               do_scan;
   logic [COMMA_W-1:0] comma_base;
   logic [FCC_W-1:0]   fcc_base;
   logic [7:0]         status_base;
   logic [LEN_W-1:0]   lens_base [0:SLOTS-1];
   logic               slot_hit;
   logic [2:0]         slot;
   logic               wr_en;

   assign byte_ready = !queue_full;
   assign accept     = byte_valid && byte_ready;

   always_comb begin
      pos_base  = (byte_data == CH_DOLLAR) ? '0 : pos_ff;
      start     = (pos_base == '0);
      in_header = (pos_base <= POS_W'(HEADER_LAST));
      hdr_ok    = (hdr_ff[0] == CH_DOLLAR) && (hdr_ff[1] == CH_M) && (hdr_ff[2] == CH_C);
      nl_emit   = !in_header && hdr_ok && (byte_data == CH_NEWLINE);
      do_scan   = in_header ||
                  (hdr_ok && (byte_data != CH_NEWLINE) && (pos_base < POS_W'(LINE_LIMIT)));

      // a new sentence starts from a clean scan state
      comma_base  = start ? '0 : comma_ff;
      fcc_base    = start ? '0 : fcc_ff;
      status_base = start ? '0 : status_ff;
      for (int s = 0; s < SLOTS; s++) begin
         lens_base[s] = start ? '0 : lens_ff[s];
      end

      // map comma count to the capture slot
      slot_hit = 1'b1;
      unique case (comma_base)
         3'd1:    slot = CODE_TIME;
         3'd3:    slot = CODE_LAT;
         3'd4:    slot = CODE_NS;
         3'd5:    slot = CODE_LON;
         3'd6:    slot = CODE_EW;
         default: begin
            slot     = CODE_TIME;
            slot_hit = 1'b0;
         end
      endcase

      pos_in    = pos_ff;
      comma_in  = comma_ff;
      fcc_in    = fcc_ff;
      status_in = status_ff;
      hdr_in    = hdr_ff;
      lens_in   = lens_ff;
      wr_en     = 1'b0;

      if (accept && nl_emit) begin
         pos_in    = '0;
         comma_in  = '0;
         fcc_in    = '0;
         status_in = '0;
         hdr_in[0] = '0;
         hdr_in[1] = '0;
         hdr_in[2] = '0;
         for (int s = 0; s < SLOTS; s++) begin
            lens_in[s] = '0;
         end
      end else if (accept && do_scan) begin
         pos_in    = pos_base + POS_W'(1);
         comma_in  = comma_base;
         fcc_in    = fcc_base;
         status_in = status_base;
         lens_in   = lens_base;
         if (in_header) begin
            if (start) begin
               hdr_in[0] = byte_data;
               hdr_in[1] = '0;
               hdr_in[2] = '0;
            end else if (pos_base == POS_W'(4)) begin
               hdr_in[1] = byte_data;
            end else if (pos_base == POS_W'(HEADER_LAST)) begin
               hdr_in[2] = byte_data;
            end
         end
         if (byte_data == CH_COMMA) begin
            if (comma_base < COMMA_MAX) begin
               comma_in = comma_base + COMMA_W'(1);
            end
            fcc_in = '0;
         end else if (comma_base == 3'd2) begin
            // status keeps its first character only
            if (fcc_base == '0) begin
               status_in = byte_data;
               fcc_in    = FCC_W'(1);
            end
         end else if (slot_hit && (fcc_base < slot_cap(slot))) begin
            wr_en         = 1'b1;
            fcc_in        = fcc_base + FCC_W'(1);
            lens_in[slot] = LEN_W'(fcc_base + FCC_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         comma_ff  <= '0;
         fcc_ff    <= '0;
         status_ff <= '0;
         for (int h = 0; h < 3; h++) begin
            hdr_ff[h] <= '0;
         end
         for (int s = 0; s < SLOTS; s++) begin
            lens_ff[s] <= '0;
         end
      end else begin
         pos_ff    <= pos_in;
         comma_ff  <= comma_in;
         fcc_ff    <= fcc_in;
         status_ff <= status_in;
         hdr_ff    <= hdr_in;
         lens_ff   <= lens_in;
      end
   end

   // character store, tails past the length are masked on the way out
   always_ff @(posedge clock) begin
      if (wr_en) begin
         chars_ff[slot][fcc_base*8 +: 8] <= byte_data;
      end
   end

   always_comb begin
      push               = accept && nl_emit;
      push_data.complete = (comma_ff == COMMA_MAX);
      push_data.fix      = (status_ff == CH_A);
      for (int s = 0; s < SLOTS; s++) begin
         push_data.lens[s]  = lens_ff[s];
         push_data.chars[s] = chars_ff[s];
      end
   end

endmodule

>>> rtl/nrfe_queue.sv
module nrfe_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  nrfe_pkg::sentence_type push_data,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output nrfe_pkg::sentence_type head
);
   import nrfe_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   sentence_type     store_ff [0:QUEUE_DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

endmodule

>>> rtl/nrfe_back.sv
module nrfe_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  nrfe_pkg::sentence_type        head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_field_code,
   output logic [nrfe_pkg::LEN_W-1:0]    rsp_field_length,
   output logic [nrfe_pkg::LOW_W-1:0]    rsp_chars_low,
   output logic [nrfe_pkg::HIGH_W-1:0]   rsp_chars_high,
   output logic                          rsp_fix_valid,
   output logic                          rsp_last
);
   import nrfe_pkg::*;

   logic               rsp_valid_ff;
   logic [2:0]         rec_ff, rec_in;
   logic [2:0]         code_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [CHARS_W-1:0] chars_ff;
   logic               fix_ff;
   logic               last_ff;

   logic               load;
   logic               rec_last;
   logic [CHARS_W-1:0] slot_chars;
   logic [LEN_W-1:0]   slot_len;
   logic [CHARS_W-1:0] masked;

   always_comb begin
      slot_chars = head.chars[rec_ff];
      slot_len   = head.lens[rec_ff];
      for (int i = 0; i < MAX_CHARS; i++) begin
         masked[i*8 +: 8] = (LEN_W'(i) < slot_len) ? slot_chars[i*8 +: 8] : 8'h00;
      end
      load     = q_valid && (!rsp_valid_ff || rsp_ready);
      rec_last = !head.complete || (rec_ff == CODE_EW);
      pop      = load && rec_last;
      rec_in   = rec_ff;
      if (load) begin
         rec_in = rec_last ? '0 : rec_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rec_ff       <= '0;
      end else begin
         rec_ff <= rec_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (head.complete) begin
            code_ff  <= rec_ff;
            len_ff   <= slot_len;
            chars_ff <= masked;
            fix_ff   <= head.fix;
            last_ff  <= (rec_ff == CODE_EW);
         end else begin
            code_ff  <= CODE_ERROR;
            len_ff   <= '0;
            chars_ff <= '0;
            fix_ff   <= 1'b0;
            last_ff  <= 1'b1;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_field_code   = code_ff;
   assign rsp_field_length = len_ff;
   assign rsp_chars_low    = chars_ff[LOW_W-1:0];
   assign rsp_chars_high   = chars_ff[CHARS_W-1:LOW_W];
   assign rsp_fix_valid    = fix_ff;
   assign rsp_last         = last_ff;

   a_rec_range: assert property (@(posedge clock) disable iff (reset)
      rec_ff <= 3'(CODE_EW))
      else $error("record counter out of range");

   a_last_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_ff) |-> (code_ff == CODE_EW || code_ff == CODE_ERROR))
      else $error("last flag on a middle record");

   a_error_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && code_ff == CODE_ERROR) |-> (len_ff == '0 && !fix_ff && last_ff))
      else $error("malformed format error record");

endmodule

>>> rtl/nmea_rmc_field_extractor_core.sv
// nmea rmc field extractor
//
// req channel: one received uart character per word (req_rx_byte), valid/ready.
// rsp channel: one field record per word, valid/ready. a newline that closes an
//   rmc sentence yields five records (utc time, latitude, n/s, longitude, e/w,
//   rsp_last on the fifth), or a single format error record (code 5) when fewer
//   than seven commas came. other sentences produce nothing.
// throughput: one character per cycle unless the queue is full. the parser front
//   end and the record back end are split by a two-sentence queue; the back end
//   sends one record per cycle while rsp_ready is high, so req_ready only drops
//   when two finished sentences still wait for the receiver.
// output: the accepted newline pushes the sentence into the queue, and its first
//   record is then registered onto rsp_; the rest follow one per cycle while rsp_ready is high.
// reset: synchronous, active high; clears the parser state, empties the queue
//   and drops rsp_valid. no clearing pass is needed.
// receiver stall: the record held on rsp_ stays put; characters keep flowing in
//   until the queue fills.
module nmea_rmc_field_extractor_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_field_code,
   output logic [nrfe_pkg::LEN_W-1:0]    rsp_field_length,
   output logic [nrfe_pkg::LOW_W-1:0]    rsp_chars_low,
   output logic [nrfe_pkg::HIGH_W-1:0]   rsp_chars_high,
   output logic                          rsp_fix_valid,
   output logic                          rsp_last
);
   import nrfe_pkg::*;

   // handoff between parser and record stage
   logic         push;
   sentence_type push_data;
   logic         queue_full;
   logic         q_valid;
   sentence_type head;
   logic         pop;

   // parser: header check, comma tracking, field capture
   nrfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_valid),
      .byte_data  (req_rx_byte),
      .queue_full (queue_full),
      .byte_ready (req_ready),
      .push       (push),
      .push_data  (push_data)
   );

   // finished sentences waiting for the record stage
   nrfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (q_valid),
      .head      (head)
   );

   // record stage: walks the five fields of the head sentence into rsp_, or one error record if it is incomplete
   nrfe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_field_code   (rsp_field_code),
      .rsp_field_length (rsp_field_length),
      .rsp_chars_low    (rsp_chars_low),
      .rsp_chars_high   (rsp_chars_high),
      .rsp_fix_valid    (rsp_fix_valid),
      .rsp_last         (rsp_last)
   );

endmodule
